>>> sv/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-slot stopwatch table package
// Transaction types, status codes and fixed constants shared by the
// stopwatch table modules.
// ----------------------------------------------------------------------------
package pst_pkg;

  // Event modes.
  localparam logic MODE_ENTRY = 1'b0;
  localparam logic MODE_EXIT  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT   = 2'd1;
  localparam logic [1:0] ST_REENTRY    = 2'd2;
  localparam logic [1:0] ST_EARLY_EXIT = 2'd3;

  // Region counter values: never entered, and the saturation point.
  localparam logic signed [31:0] COUNT_NEVER = -32'sd1;
  localparam logic signed [31:0] COUNT_TOP   = 32'sh7FFF_FFFF;

  // Reset value of the slot count register.
  localparam logic [6:0] ACTIVE_SLOTS_RESET = 7'd64;

  // Input transaction: one entry or exit event.
  typedef struct packed {
    logic        mode;
    logic [5:0]  slot;
    logic [47:0] timestamp;
  } pst_in_t;

  // Output transaction: status and the slot's values after the event.
  typedef struct packed {
    logic [1:0]         status;
    logic [47:0]        last_span;
    logic [63:0]        total_span;
    logic signed [31:0] region_count;
  } pst_out_t;

  // Write control from the update logic to the slot store.
  typedef struct packed {
    logic wr_en;
    logic inside_next;
  } pst_wr_t;

endpackage

>>> sv/per_slot_runtime_stopwatch_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-slot runtime stopwatch table
// Top level: input handshake, record read stage, update and result register.
// ----------------------------------------------------------------------------
// The table accepts one entry or exit event per clock cycle and returns one
// result per event. The result is presented from the result register once
// its event has left the read stage and is taken at an edge where the output
// is not stalled. On acceptance the slot's record is read from a record
// memory with one read port and one write port; the read stage then resolves
// it (with forwarding of the write made by the previous event), applies the
// event and, once the result register is free, writes the record back and
// loads the result register. Throughput is one event per cycle, set by that
// one read and one write per cycle on the record memory; a stalled result
// holds the read stage and stalls the input. Per-slot valid bits reset with
// the block, so no clearing pass is needed after reset.
module per_slot_runtime_stopwatch_table #(
  parameter int MAX_SLOTS = 64,
  parameter int TIME_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pst_pkg::pst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pst_pkg::pst_out_t out_data,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int REC_W = 2 * TIME_BITS + 96;

  logic [6:0]        active_slots;
  logic              s1_valid;
  pst_pkg::pst_in_t  s1_item;
  logic              advance;
  logic              in_accept;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cur_idx;
  logic [REC_W-1:0]  cur_rec;
  logic [REC_W-1:0]  new_rec;
  logic              cur_inside;
  pst_pkg::pst_wr_t  upd_wr;
  pst_pkg::pst_wr_t  store_wr;
  pst_pkg::pst_out_t result;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= pst_pkg::ACTIVE_SLOTS_RESET;
    end else if (cfg_we) begin
      active_slots <= cfg_wdata;
    end
  end

  // Handshake: the read stage moves on when the result register is free.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  assign rd_idx  = IDX_W'(in_data.slot);
  assign cur_idx = IDX_W'(s1_item.slot);

  // Read stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_item <= in_data;
    end
  end

  // Write back only when the event is handed on to the result register.
  assign store_wr.wr_en       = upd_wr.wr_en && s1_valid && advance;
  assign store_wr.inside_next = upd_wr.inside_next;

  pst_store #(
    .MAX_SLOTS (MAX_SLOTS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_accept),
    .rd_idx     (rd_idx),
    .cur_idx    (cur_idx),
    .wr         (store_wr),
    .wr_rec     (new_rec),
    .cur_rec    (cur_rec),
    .cur_inside (cur_inside)
  );

  pst_update #(
    .MAX_SLOTS (MAX_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .item         (s1_item),
    .active_slots (active_slots),
    .in_region    (cur_inside),
    .rec          (cur_rec),
    .new_rec      (new_rec),
    .wr           (upd_wr),
    .result       (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  // A stall towards the source is only raised with an event in the read stage.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty read stage");

  // An out-of-range slot reports all-zero values.
  a_bad_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == pst_pkg::ST_BAD_SLOT)) |->
    ((out_data.last_span == '0) && (out_data.total_span == '0) &&
     (out_data.region_count == '0)))
    else $error("invalid slot result carries slot values");

  // A successful event always leaves a non-negative region count.
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == pst_pkg::ST_OK)) |->
    !out_data.region_count[31])
    else $error("successful event reports a negative region count");

  // Nothing is written back while the event is held in the read stage.
  a_no_write_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !store_wr.wr_en)
    else $error("record written while the event is stalled");
`endif

endmodule

>>> sv/pst_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot store
// Record memory with registered read, per-slot valid and inside flags, and
// a forwarding register that covers a write landing on the read edge.
// ----------------------------------------------------------------------------
module pst_store #(
  parameter int MAX_SLOTS = 64,
  parameter int TIME_BITS = 48,
  parameter int IDX_W     = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_idx,
  input  logic [IDX_W-1:0]       cur_idx,
  input  pst_pkg::pst_wr_t       wr,
  input  logic [2*TIME_BITS+95:0] wr_rec,
  output logic [2*TIME_BITS+95:0] cur_rec,
  output logic                   cur_inside
);

  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] last;
    logic [63:0]          total;
    logic signed [31:0]   count;
  } rec_t;

  localparam rec_t RESET_REC = '{start: '0, last: '0, total: '0,
                                 count: pst_pkg::COUNT_NEVER};

  rec_t                 mem [MAX_SLOTS];
  rec_t                 rd_rec;
  rec_t                 fwd_rec;
  logic [IDX_W-1:0]     fwd_idx;
  logic                 fwd_valid;
  logic [MAX_SLOTS-1:0] rec_valid;
  logic [MAX_SLOTS-1:0] inside_flag;

  // Record memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[cur_idx] <= rec_t'(wr_rec);
    end
    if (rd_en) begin
      rd_rec <= mem[rd_idx];
    end
  end

  // The most recent write, kept for a read that raced it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr.wr_en) begin
      fwd_valid <= 1'b1;
    end
    if (wr.wr_en) begin
      fwd_idx <= cur_idx;
      fwd_rec <= rec_t'(wr_rec);
    end
  end

  // Per-slot flags; a slot without a valid record reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid   <= '0;
      inside_flag <= '0;
    end else if (wr.wr_en) begin
      rec_valid[cur_idx]   <= 1'b1;
      inside_flag[cur_idx] <= wr.inside_next;
    end
  end

  // Resolve the record for the slot now being processed.
  always_comb begin
    if (!rec_valid[cur_idx]) begin
      cur_rec = RESET_REC;
    end else if (fwd_valid && (fwd_idx == cur_idx)) begin
      cur_rec = fwd_rec;
    end else begin
      cur_rec = rd_rec;
    end
    cur_inside = inside_flag[cur_idx];
  end

endmodule

>>> sv/pst_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event update
// Checks one event against the slot state, computes the new record and
// builds the result transaction.
// ----------------------------------------------------------------------------
module pst_update #(
  parameter int MAX_SLOTS = 64,
  parameter int TIME_BITS = 48
) (
  input  pst_pkg::pst_in_t        item,
  input  logic [6:0]              active_slots,
  input  logic                    in_region,
  input  logic [2*TIME_BITS+95:0] rec,
  output logic [2*TIME_BITS+95:0] new_rec,
  output pst_pkg::pst_wr_t        wr,
  output pst_pkg::pst_out_t       result
);

  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] last;
    logic [63:0]          total;
    logic signed [31:0]   count;
  } rec_t;

  rec_t                 cur;
  rec_t                 upd;
  logic                 in_range;
  logic [TIME_BITS-1:0] ts;
  logic [TIME_BITS-1:0] elapsed;
  logic [64:0]          sum;
  logic signed [31:0]   count_base;
  logic [1:0]           status;

  assign cur = rec_t'(rec);

  // Slot must lie below both the programmed count and the table depth.
  assign in_range = (32'(item.slot) < 32'(active_slots)) &&
                    (32'(item.slot) < MAX_SLOTS);

  // Timestamp and elapsed time wrap at the time width.
  assign ts      = TIME_BITS'(item.timestamp);
  assign elapsed = ts - cur.start;
  assign sum     = {1'b0, cur.total} + 65'(elapsed);

  // A first entry moves the count off its never-entered value.
  assign count_base = (cur.count == pst_pkg::COUNT_NEVER) ? '0 : cur.count;

  // Status and next record.
  always_comb begin
    upd            = cur;
    wr.inside_next = 1'b0;
    if (!in_range) begin
      status = pst_pkg::ST_BAD_SLOT;
    end else if (item.mode == pst_pkg::MODE_ENTRY) begin
      if (in_region) begin
        status = pst_pkg::ST_REENTRY;
      end else begin
        status         = pst_pkg::ST_OK;
        upd.start      = ts;
        upd.count      = count_base;
        wr.inside_next = 1'b1;
      end
    end else begin
      if (!in_region) begin
        status = pst_pkg::ST_EARLY_EXIT;
      end else begin
        status    = pst_pkg::ST_OK;
        upd.last  = elapsed;
        upd.total = sum[64] ? '1 : sum[63:0];
        upd.count = (count_base < pst_pkg::COUNT_TOP) ? count_base + 32'sd1
                                                      : count_base;
      end
    end
    wr.wr_en = (status == pst_pkg::ST_OK);
  end

  assign new_rec = upd;

  // Result fields read zero for a slot out of range.
  always_comb begin
    result.status = status;
    if (in_range) begin
      result.last_span    = 48'(upd.last);
      result.total_span   = upd.total;
      result.region_count = upd.count;
    end else begin
      result.last_span    = '0;
      result.total_span   = '0;
      result.region_count = '0;
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch table testbench
// Drives entry and exit events into the per-slot stopwatch table and checks
// every result against an in-bench model of the slot records. It runs a short
// directed sequence and several random phases under different slot counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          SLOT_DEPTH = 64;
  localparam logic [47:0] TS_MAX     = 48'hFFFF_FFFF_FFFF;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  // Model of the slot records and the queue of results still to arrive.
  class slot_timer_ledger;
    logic [6:0]         active_slots;
    bit                 in_region [SLOT_DEPTH];
    logic [47:0]        start_at [SLOT_DEPTH];
    logic [47:0]        last_ticks [SLOT_DEPTH];
    logic [63:0]        total_ticks [SLOT_DEPTH];
    logic signed [31:0] region_count [SLOT_DEPTH];
    pst_pkg::pst_out_t  due_results [$];
    int                 errors;

    function new();
      active_slots = pst_pkg::ACTIVE_SLOTS_RESET;
      errors = 0;
      for (int i = 0; i < SLOT_DEPTH; i++) begin
        in_region[i]    = 1'b0;
        start_at[i]     = '0;
        last_ticks[i]   = '0;
        total_ticks[i]  = '0;
        region_count[i] = pst_pkg::COUNT_NEVER;
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void log_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Applies one accepted event and queues the result it must produce.
    function void note_event(pst_pkg::pst_in_t ev);
      pst_pkg::pst_out_t res;
      int unsigned       lim;
      int unsigned       s;
      logic [47:0]       elapsed;
      logic [64:0]       sum;
      lim = (active_slots > SLOT_DEPTH) ? SLOT_DEPTH : active_slots;
      s = ev.slot;
      res = '0;
      if (s >= lim) begin
        res.status = pst_pkg::ST_BAD_SLOT;
      end else if (ev.mode == pst_pkg::MODE_ENTRY && in_region[s]) begin
        res.status = pst_pkg::ST_REENTRY;
      end else if (ev.mode == pst_pkg::MODE_EXIT && !in_region[s]) begin
        res.status = pst_pkg::ST_EARLY_EXIT;
      end else begin
        res.status = pst_pkg::ST_OK;
        if (ev.mode == pst_pkg::MODE_ENTRY) begin
          in_region[s] = 1'b1;
          start_at[s]  = ev.timestamp;
          if (region_count[s] == pst_pkg::COUNT_NEVER) region_count[s] = '0;
        end else begin
          elapsed       = ev.timestamp - start_at[s];
          last_ticks[s] = elapsed;
          in_region[s]  = 1'b0;
          sum = {1'b0, total_ticks[s]} + {17'd0, elapsed};
          total_ticks[s] = sum[64] ? '1 : sum[63:0];
          if (region_count[s] == pst_pkg::COUNT_NEVER) region_count[s] = '0;
          if (region_count[s] < pst_pkg::COUNT_TOP)
            region_count[s] = region_count[s] + 32'sd1;
        end
      end
      // An invalid slot reports zeros; every other outcome reports the record.
      if (res.status != pst_pkg::ST_BAD_SLOT) begin
        res.last_span    = last_ticks[s];
        res.total_span   = total_ticks[s];
        res.region_count = region_count[s];
      end
      due_results.push_back(res);
    endfunction

    // Compares one delivered result with the oldest one still due.
    function void check_result(pst_pkg::pst_out_t got);
      pst_pkg::pst_out_t want;
      if (due_results.size() == 0) begin
        log_mismatch($sformatf("result with no event pending, status %0d", got.status));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        log_mismatch($sformatf("status expected %0d got %0d", want.status, got.status));
      if (got.last_span !== want.last_span)
        log_mismatch($sformatf("last_span expected %h got %h",
                               want.last_span, got.last_span));
      if (got.total_span !== want.total_span)
        log_mismatch($sformatf("total_span expected %h got %h",
                               want.total_span, got.total_span));
      if (got.region_count !== want.region_count)
        log_mismatch($sformatf("region_count expected %0d got %0d",
                               want.region_count, got.region_count));
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  pst_pkg::pst_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pst_pkg::pst_out_t out_data;
  logic              cfg_we    = 1'b0;
  logic [6:0]        cfg_wdata = '0;

  slot_timer_ledger ledger;
  int               n_in = 0;
  int               burst_left = 0;
  logic [6:0]       cur_slots = pst_pkg::ACTIVE_SLOTS_RESET;
  bit               gen_inside [SLOT_DEPTH];
  logic [47:0]      gen_start [SLOT_DEPTH];

  per_slot_runtime_stopwatch_table u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels and hand each completed transaction to the ledger.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        ledger.note_event(in_data);
        n_in <= n_in + 1;
      end
      if (out_valid && !out_stall) ledger.check_result(out_data);
    end
  end

  // Receiver stall pattern, with two long hold-offs while the sender keeps going.
  initial begin : receiver_pattern
    stall_mode_t mode;
    int          left;
    int          hold_left;
    int          holds_done;
    mode = STALL_NONE;
    left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < 2 && n_in >= 120 + 210 * holds_done) begin
        hold_left = 100;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 2));
          left = $urandom_range(8, 60);
        end
        left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
          default:     out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // Presents one transaction, with a random gap whenever a burst runs out.
  task automatic push_event(pst_pkg::pst_in_t ev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Keeps the generator's own view of which slots are inside, then sends.
  task automatic offer_event(logic mode, logic [5:0] slot, logic [47:0] ts);
    pst_pkg::pst_in_t ev;
    int unsigned      lim;
    ev.mode      = mode;
    ev.slot      = slot;
    ev.timestamp = ts;
    lim = (cur_slots > SLOT_DEPTH) ? SLOT_DEPTH : cur_slots;
    if (slot < lim) begin
      if (mode == pst_pkg::MODE_ENTRY && !gen_inside[slot]) begin
        gen_inside[slot] = 1'b1;
        gen_start[slot]  = ts;
      end else if (mode == pst_pkg::MODE_EXIT && gen_inside[slot]) begin
        gen_inside[slot] = 1'b0;
      end
    end
    push_event(ev);
  endtask

  // Stops offering and waits until every result has come back. The first
  // edge lets the monitor log a transaction accepted on the last edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slots(logic [6:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.active_slots = value;
    cur_slots = value;
  endtask

  function automatic logic [47:0] rand_ts();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [47:0] entry_time();
    case ($urandom_range(0, 9))
      5, 6:    return TS_MAX - 48'($urandom_range(0, 500));
      7:       return 48'($urandom_range(0, 500));
      default: return rand_ts();
    endcase
  endfunction

  function automatic logic [47:0] exit_delay();
    case ($urandom_range(0, 9))
      5, 6:    return 48'($urandom);
      7:       return rand_ts();
      8:       return TS_MAX - 48'($urandom_range(0, 100));
      9:       return '0;
      default: return 48'($urandom_range(0, 2000));
    endcase
  endfunction

  // Mostly well-formed entry and exit pairs on a few busy slots, plus noise,
  // out-of-range slots and events in the wrong order.
  task automatic run_traffic(int n);
    int unsigned lim;
    int unsigned pick;
    int unsigned hot;
    logic [5:0]  s;
    logic        m;
    logic [47:0] ts;
    repeat (n) begin
      lim  = (cur_slots > SLOT_DEPTH) ? SLOT_DEPTH : cur_slots;
      pick = $urandom_range(0, 99);
      if (lim == 0 || pick < 6) begin
        m  = 1'($urandom_range(0, 1));
        s  = 6'($urandom_range(0, SLOT_DEPTH - 1));
        ts = rand_ts();
      end else if (pick < 12 && lim < SLOT_DEPTH) begin
        m  = 1'($urandom_range(0, 1));
        s  = 6'($urandom_range(lim, SLOT_DEPTH - 1));
        ts = rand_ts();
      end else begin
        hot = (lim < 6) ? lim : 6;
        if ($urandom_range(0, 99) < 70) s = 6'($urandom_range(0, hot - 1));
        else s = 6'($urandom_range(0, lim - 1));
        m = gen_inside[s] ? pst_pkg::MODE_EXIT : pst_pkg::MODE_ENTRY;
        if (pick < 20) m = ~m;
        if (m == pst_pkg::MODE_ENTRY) ts = entry_time();
        else ts = gen_start[s] + exit_delay();
      end
      offer_event(m, s, ts);
    end
  endtask

  // Main sequence.
  initial begin
    ledger = new();
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      gen_inside[i] = 1'b0;
      gen_start[i]  = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Ordering errors, zero and extreme times, and wrap-around of elapsed time.
    offer_event(pst_pkg::MODE_EXIT, 6'd0, 48'd0);
    offer_event(pst_pkg::MODE_ENTRY, 6'd0, 48'd0);
    offer_event(pst_pkg::MODE_ENTRY, 6'd0, 48'd123);
    offer_event(pst_pkg::MODE_EXIT, 6'd0, 48'd0);
    offer_event(pst_pkg::MODE_ENTRY, 6'd63, TS_MAX);
    offer_event(pst_pkg::MODE_EXIT, 6'd63, 48'd5);
    offer_event(pst_pkg::MODE_ENTRY, 6'd5, 48'd5);
    offer_event(pst_pkg::MODE_EXIT, 6'd5, 48'd4);
    offer_event(pst_pkg::MODE_ENTRY, 6'd1, 48'h5555_5555_5555);
    offer_event(pst_pkg::MODE_EXIT, 6'd1, 48'hAAAA_AAAA_AAAA);
    offer_event(pst_pkg::MODE_ENTRY, 6'd2, 48'd7);

    // Slot count changes: one slot, none, above the table size, and back.
    write_slots(7'd1);
    offer_event(pst_pkg::MODE_ENTRY, 6'd1, 48'd0);
    offer_event(pst_pkg::MODE_EXIT, 6'd0, 48'd9);
    write_slots(7'd0);
    offer_event(pst_pkg::MODE_ENTRY, 6'd0, 48'd0);
    offer_event(pst_pkg::MODE_EXIT, 6'd63, 48'd0);
    write_slots(7'd127);
    offer_event(pst_pkg::MODE_EXIT, 6'd63, 48'd0);
    offer_event(pst_pkg::MODE_ENTRY, 6'd63, 48'd100);
    write_slots(7'd3);
    offer_event(pst_pkg::MODE_EXIT, 6'd2, 48'd1000);
    offer_event(pst_pkg::MODE_EXIT, 6'd63, 48'd50);
    write_slots(7'd64);
    offer_event(pst_pkg::MODE_EXIT, 6'd63, 48'd50);

    // Random phases under a spread of slot counts.
    run_traffic(90);
    write_slots(7'd20);
    run_traffic(60);
    write_slots(7'd127);
    run_traffic(80);
    write_slots(7'd1);
    run_traffic(30);
    write_slots(7'd45);
    run_traffic(70);
    write_slots(7'd9);
    run_traffic(50);
    write_slots(7'd64);
    run_traffic(50);

    in_valid <= 1'b0;
    @(posedge clk);
    for (int guard = 0; guard < 20000 && ledger.outstanding() != 0; guard++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
